### sv/bqlp_pkg.sv
// Shared types, constants and the arctangent table of the lowpass coefficient calculator.
`default_nettype none
package bqlp_pkg;

    localparam int XW = 34;
    localparam int DW = 40;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_QZERO = 2'd1;
    localparam logic [1:0] ST_CLAMP = 2'd2;

    localparam logic [27:0] ISR_RESET   = 28'd22906492;
    localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
    localparam logic signed [XW-1:0] CORDIC_X0 = 34'sd652032874;
    localparam logic signed [XW-1:0] ONE_Q30   = 34'sd1073741824;

    typedef struct packed {
        logic [15:0] q;
        logic [15:0] g;
        logic        neg_cos;
        logic [1:0]  status;
    } t_tag;

    typedef struct packed {
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [XW-1:0] z;
        t_tag                 tag;
    } t_rot;

    function automatic logic signed [XW-1:0] atan_q30(input logic [4:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:  v = 32'h3243F6A8;
            5'd1:  v = 32'h1DAC6705;
            5'd2:  v = 32'h0FADBAFC;
            5'd3:  v = 32'h07F56EA6;
            5'd4:  v = 32'h03FEAB76;
            5'd5:  v = 32'h01FFD55B;
            5'd6:  v = 32'h00FFFAAA;
            5'd7:  v = 32'h007FFF55;
            5'd8:  v = 32'h003FFFEA;
            5'd9:  v = 32'h001FFFFD;
            5'd10: v = 32'h000FFFFF;
            5'd11: v = 32'h0007FFFF;
            5'd12: v = 32'h0003FFFF;
            5'd13: v = 32'h0001FFFF;
            5'd14: v = 32'h0000FFFF;
            5'd15: v = 32'h00007FFF;
            5'd16: v = 32'h00003FFF;
            5'd17: v = 32'h00001FFF;
            5'd18: v = 32'h00000FFF;
            5'd19: v = 32'h000007FF;
            5'd20: v = 32'h000003FF;
            5'd21: v = 32'h000001FF;
            5'd22: v = 32'h000000FF;
            5'd23: v = 32'h0000007F;
            5'd24: v = 32'h0000003F;
            5'd25: v = 32'h0000001F;
            5'd26: v = 32'h0000000F;
            5'd27: v = 32'h00000008;
            5'd28: v = 32'h00000004;
            5'd29: v = 32'h00000002;
            5'd30: v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return signed'(XW'(v));
    endfunction

endpackage
`default_nettype wire

### sv/bqlp_phase.sv
// Front stages: phase product, Nyquist clamp, quadrant fold and angle scaling.
`default_nettype none
module bqlp_phase import bqlp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [23:0] i_centre_freq,
    input  logic [15:0] i_resonance_q,
    input  logic [15:0] i_gain_value,
    input  logic [27:0] i_inv_sample_rate,
    output logic        o_valid,
    input  logic        i_ready,
    output t_rot        o_rot
);

    localparam logic [51:0] NYQ = 52'h8000_0000_0000;

    logic        r_va, r_vb, r_vc;
    logic [51:0] r_p;
    t_tag        r_tag_a, r_tag_b;
    logic [30:0] r_t;
    t_rot        r_rot;

    logic        w_go_a, w_go_b, w_go_c;
    logic [51:0] w_pc;
    logic [31:0] w_t;
    logic        w_fold;
    logic [31:0] n_t;
    t_tag        n_tag_b;
    logic [61:0] w_prod;
    logic [31:0] w_z;

    assign w_go_c  = !r_vc || i_ready;
    assign w_go_b  = !r_vb || w_go_c;
    assign w_go_a  = !r_va || w_go_b;
    assign o_ready = w_go_a;
    assign o_valid = r_vc;
    assign o_rot   = r_rot;

    always_comb begin
        w_pc   = (r_p >= NYQ) ? NYQ : r_p;
        w_t    = 32'((w_pc + 52'h8000) >> 16);
        w_fold = w_t > 32'h4000_0000;
        n_t    = w_fold ? (32'h8000_0000 - w_t) : w_t;
        n_tag_b = r_tag_a;
        n_tag_b.neg_cos = w_fold;
        if (r_tag_a.status != ST_QZERO && r_p >= NYQ) begin
            n_tag_b.status = ST_CLAMP;
        end
        w_prod = 62'(r_t) * 62'(HALF_PI_Q30);
        w_z    = 32'((w_prod + 62'h2000_0000) >> 30);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
        end else begin
            if (w_go_a) begin
                r_va <= i_valid;
            end
            if (w_go_b) begin
                r_vb <= r_va;
            end
            if (w_go_c) begin
                r_vc <= r_vb;
            end
        end
        if (w_go_a && i_valid) begin
            r_p           <= 52'(i_centre_freq) * 52'(i_inv_sample_rate);
            r_tag_a.q     <= i_resonance_q;
            r_tag_a.g     <= i_gain_value;
            r_tag_a.neg_cos <= 1'b0;
            r_tag_a.status  <= (i_resonance_q == 16'd0) ? ST_QZERO : ST_OK;
        end
        if (w_go_b && r_va) begin
            r_t     <= n_t[30:0];
            r_tag_b <= n_tag_b;
        end
        if (w_go_c && r_vb) begin
            r_rot.x   <= CORDIC_X0;
            r_rot.y   <= '0;
            r_rot.z   <= signed'(XW'(w_z));
            r_rot.tag <= r_tag_b;
        end
    end

endmodule
`default_nettype wire

### sv/bqlp_cordic_cell.sv
// One rotation step of the sine and cosine chain.
`default_nettype none
module bqlp_cordic_cell import bqlp_pkg::*; #(
    parameter int STEP = 0
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_rot i_rot,
    output logic o_valid,
    input  logic i_ready,
    output t_rot o_rot
);

    logic r_v;
    t_rot r_rot;
    t_rot n_rot;
    logic w_go;
    logic signed [XW-1:0] w_dx, w_dy, w_at;

    assign w_go    = !r_v || i_ready;
    assign o_ready = w_go;
    assign o_valid = r_v;
    assign o_rot   = r_rot;

    always_comb begin
        w_dx  = i_rot.y >>> STEP;
        w_dy  = i_rot.x >>> STEP;
        w_at  = atan_q30(5'(STEP));
        n_rot = i_rot;
        if (!i_rot.z[XW-1]) begin
            n_rot.x = i_rot.x - w_dx;
            n_rot.y = i_rot.y + w_dy;
            n_rot.z = i_rot.z - w_at;
        end else begin
            n_rot.x = i_rot.x + w_dx;
            n_rot.y = i_rot.y - w_dy;
            n_rot.z = i_rot.z + w_at;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (w_go) begin
            r_v <= i_valid;
        end
        if (w_go && i_valid) begin
            r_rot <= n_rot;
        end
    end

endmodule
`default_nettype wire

### sv/bqlp_prep.sv
// Sine and cosine clamp, divisor and numerator products, and divider setup.
`default_nettype none
module bqlp_prep import bqlp_pkg::*; #(
    parameter int COEF_FRAC_BITS = 26
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_rot i_rot,
    output logic o_valid,
    input  logic i_ready,
    output logic [3*DW+3*(COEF_FRAC_BITS+6)+DW+4-1:0] o_div
);

    localparam int QW = COEF_FRAC_BITS + 6;
    localparam int NW = 64 + COEF_FRAC_BITS + 1;

    typedef struct packed {
        logic [DW-1:0] d;
        logic [DW-1:0] r_b0;
        logic [DW-1:0] r_a1;
        logic [DW-1:0] r_a2;
        logic [QW-1:0] nq_b0;
        logic [QW-1:0] nq_a1;
        logic [QW-1:0] nq_a2;
        logic          neg_a1;
        logic          neg_a2;
        logic [1:0]    status;
    } t_div;

    logic w_go1, w_go2, w_go3;
    logic r_v1, r_v2, r_v3;

    logic [30:0] w_s, w_cm;
    logic [31:0] w_ompc;
    logic [38:0] w_twoq;
    logic        w_a2neg;

    logic [DW-1:0] r1_d, r1_a2mag;
    logic          r1_a1neg, r1_a2neg;
    logic [30:0]   r1_cm;
    logic [31:0]   r1_ompc;
    logic [15:0]   r1_q, r1_g;
    logic [1:0]    r1_status;

    logic [DW-1:0] r2_d, r2_a2mag;
    logic          r2_a1neg, r2_a2neg;
    logic [47:0]   r2_mb0;
    logic [46:0]   r2_ma1;
    logic [15:0]   r2_q;
    logic [1:0]    r2_status;

    logic [DW-1:0] r3_d, r3_a2mag;
    logic          r3_a1neg, r3_a2neg;
    logic [63:0]   r3_nb0;
    logic [46:0]   r3_ma1;
    logic [1:0]    r3_status;

    logic [NW-1:0] w_nb0, w_na1, w_na2;
    t_div          w_div;

    assign w_go3   = !r_v3 || i_ready;
    assign w_go2   = !r_v2 || w_go3;
    assign w_go1   = !r_v1 || w_go2;
    assign o_ready = w_go1;
    assign o_valid = r_v3;

    always_comb begin
        if (i_rot.y[XW-1]) begin
            w_s = '0;
        end else if (i_rot.y > ONE_Q30) begin
            w_s = 31'h4000_0000;
        end else begin
            w_s = i_rot.y[30:0];
        end
        if (i_rot.x[XW-1]) begin
            w_cm = '0;
        end else if (i_rot.x > ONE_Q30) begin
            w_cm = 31'h4000_0000;
        end else begin
            w_cm = i_rot.x[30:0];
        end
        w_ompc  = i_rot.tag.neg_cos ? (32'h4000_0000 + 32'(w_cm))
                                    : (32'h4000_0000 - 32'(w_cm));
        w_twoq  = {i_rot.tag.q, 23'd0};
        w_a2neg = 39'(w_s) > w_twoq;
    end

    always_comb begin
        w_nb0 = (NW'(r3_nb0) << (COEF_FRAC_BITS + 1)) >> 20;
        w_na1 = (NW'(r3_ma1) << (COEF_FRAC_BITS + 1)) >> 6;
        w_na2 = NW'(r3_a2mag) << (COEF_FRAC_BITS + 1);
        w_div.d      = r3_d;
        w_div.r_b0   = w_nb0[QW +: DW];
        w_div.r_a1   = w_na1[QW +: DW];
        w_div.r_a2   = w_na2[QW +: DW];
        w_div.nq_b0  = w_nb0[QW-1:0];
        w_div.nq_a1  = w_na1[QW-1:0];
        w_div.nq_a2  = w_na2[QW-1:0];
        w_div.neg_a1 = r3_a1neg;
        w_div.neg_a2 = r3_a2neg;
        w_div.status = r3_status;
    end

    assign o_div = w_div;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_go1) begin
                r_v1 <= i_valid;
            end
            if (w_go2) begin
                r_v2 <= r_v1;
            end
            if (w_go3) begin
                r_v3 <= r_v2;
            end
        end
        if (w_go1 && i_valid) begin
            r1_d      <= DW'(w_twoq) + DW'(w_s);
            r1_a2mag  <= w_a2neg ? DW'(39'(w_s) - w_twoq) : DW'(w_twoq - 39'(w_s));
            r1_a2neg  <= w_a2neg;
            r1_a1neg  <= !i_rot.tag.neg_cos && (w_cm != 31'd0);
            r1_cm     <= w_cm;
            r1_ompc   <= w_ompc;
            r1_q      <= i_rot.tag.q;
            r1_g      <= i_rot.tag.g;
            r1_status <= i_rot.tag.status;
        end
        if (w_go2 && r_v1) begin
            r2_d      <= r1_d;
            r2_a2mag  <= r1_a2mag;
            r2_a2neg  <= r1_a2neg;
            r2_a1neg  <= r1_a1neg;
            r2_mb0    <= 48'(r1_ompc) * 48'(r1_g);
            r2_ma1    <= 47'(r1_cm) * 47'(r1_q);
            r2_q      <= r1_q;
            r2_status <= r1_status;
        end
        if (w_go3 && r_v2) begin
            r3_d      <= r2_d;
            r3_a2mag  <= r2_a2mag;
            r3_a2neg  <= r2_a2neg;
            r3_a1neg  <= r2_a1neg;
            r3_nb0    <= 64'(r2_mb0) * 64'(r2_q);
            r3_ma1    <= r2_ma1;
            r3_status <= r2_status;
        end
    end

endmodule
`default_nettype wire

### sv/bqlp_div_cell.sv
// One restoring division step applied to the three coefficient quotients.
`default_nettype none
module bqlp_div_cell import bqlp_pkg::*; #(
    parameter int COEF_FRAC_BITS = 26
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  logic [3*DW+3*(COEF_FRAC_BITS+6)+DW+4-1:0] i_div,
    output logic o_valid,
    input  logic i_ready,
    output logic [3*DW+3*(COEF_FRAC_BITS+6)+DW+4-1:0] o_div
);

    localparam int QW = COEF_FRAC_BITS + 6;

    typedef struct packed {
        logic [DW-1:0] d;
        logic [DW-1:0] r_b0;
        logic [DW-1:0] r_a1;
        logic [DW-1:0] r_a2;
        logic [QW-1:0] nq_b0;
        logic [QW-1:0] nq_a1;
        logic [QW-1:0] nq_a2;
        logic          neg_a1;
        logic          neg_a2;
        logic [1:0]    status;
    } t_div;

    function automatic logic [DW+QW-1:0] div_step(input logic [DW-1:0] d,
                                                  input logic [DW-1:0] r,
                                                  input logic [QW-1:0] nq);
        logic [DW:0] r2;
        logic [DW:0] diff;
        r2   = {r, nq[QW-1]};
        diff = r2 - {1'b0, d};
        if (!diff[DW]) begin
            return {diff[DW-1:0], nq[QW-2:0], 1'b1};
        end
        return {r2[DW-1:0], nq[QW-2:0], 1'b0};
    endfunction

    logic r_v;
    t_div r_div;
    t_div w_in;
    t_div n_div;
    logic w_go;

    assign w_go    = !r_v || i_ready;
    assign o_ready = w_go;
    assign o_valid = r_v;
    assign o_div   = r_div;
    assign w_in    = i_div;

    always_comb begin
        n_div = w_in;
        {n_div.r_b0, n_div.nq_b0} = div_step(w_in.d, w_in.r_b0, w_in.nq_b0);
        {n_div.r_a1, n_div.nq_a1} = div_step(w_in.d, w_in.r_a1, w_in.nq_a1);
        {n_div.r_a2, n_div.nq_a2} = div_step(w_in.d, w_in.r_a2, w_in.nq_a2);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (w_go) begin
            r_v <= i_valid;
        end
        if (w_go && i_valid) begin
            r_div <= n_div;
        end
    end

endmodule
`default_nettype wire

### sv/biquad_lowpass_coefficient_calc_core.sv
// Chain: phase stages, rotation cells, prep stages, divider cells and an output register.
// One word per cycle unless the output stalls; every stage is its own register and cell.
// The rotation chain gives one CORDIC step per cell, the divider chain one quotient bit.
// Reset is synchronous and active low; it empties the pipeline and loads 2^40 / 48 kHz
// into the inverse sample rate register.
`default_nettype none
module biquad_lowpass_coefficient_calc_core import bqlp_pkg::*; #(
    parameter int CORDIC_STEPS   = 24,
    parameter int COEF_FRAC_BITS = 26
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [23:0] i_centre_freq,
    input  logic [15:0] i_resonance_q,
    input  logic [15:0] i_gain_value,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_coef_b0,
    output logic [31:0] o_coef_b1,
    output logic [31:0] o_coef_b2,
    output logic [31:0] o_coef_a1,
    output logic [31:0] o_coef_a2,
    output logic [1:0]  o_status
);

    localparam int QW = COEF_FRAC_BITS + 6;
    localparam int VW = 3 * DW + 3 * QW + DW + 4;

    typedef struct packed {
        logic [DW-1:0] d;
        logic [DW-1:0] r_b0;
        logic [DW-1:0] r_a1;
        logic [DW-1:0] r_a2;
        logic [QW-1:0] nq_b0;
        logic [QW-1:0] nq_a1;
        logic [QW-1:0] nq_a2;
        logic          neg_a1;
        logic          neg_a2;
        logic [1:0]    status;
    } t_div;

    function automatic logic [31:0] sat_coef(input logic [QW-1:0] q,
                                             input logic neg, input logic dbl);
        logic [QW:0]  rnd;
        logic [63:0]  mag;
        rnd = ({1'b0, q} + 1'b1) >> 1;
        mag = 64'(rnd);
        if (dbl) begin
            mag = mag << 1;
        end
        if (neg) begin
            return (mag > 64'h8000_0000) ? 32'h8000_0000 : 32'(64'd0 - mag);
        end
        return (mag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
    endfunction

    logic [27:0] r_isr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_isr <= ISR_RESET;
        end else if (psel && penable && pwrite && pready && !paddr[2]) begin
            r_isr <= pwdata[27:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = paddr[2] ? 32'd0 : 32'(r_isr);

    t_rot w_rot [CORDIC_STEPS+1];
    logic w_rv  [CORDIC_STEPS+1];
    logic w_rr  [CORDIC_STEPS+1];

    logic [VW-1:0] w_div [QW+1];
    logic          w_dv  [QW+1];
    logic          w_dr  [QW+1];

    bqlp_phase u_phase (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_in_valid),
        .o_ready          (o_in_ready),
        .i_centre_freq    (i_centre_freq),
        .i_resonance_q    (i_resonance_q),
        .i_gain_value     (i_gain_value),
        .i_inv_sample_rate(r_isr),
        .o_valid          (w_rv[0]),
        .i_ready          (w_rr[0]),
        .o_rot            (w_rot[0])
    );

    for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_rot
        bqlp_cordic_cell #(.STEP(k)) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_valid(w_rv[k]),
            .o_ready(w_rr[k]),
            .i_rot  (w_rot[k]),
            .o_valid(w_rv[k+1]),
            .i_ready(w_rr[k+1]),
            .o_rot  (w_rot[k+1])
        );
    end

    bqlp_prep #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_prep (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(w_rv[CORDIC_STEPS]),
        .o_ready(w_rr[CORDIC_STEPS]),
        .i_rot  (w_rot[CORDIC_STEPS]),
        .o_valid(w_dv[0]),
        .i_ready(w_dr[0]),
        .o_div  (w_div[0])
    );

    for (genvar k = 0; k < QW; k++) begin : g_div
        bqlp_div_cell #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_valid(w_dv[k]),
            .o_ready(w_dr[k]),
            .i_div  (w_div[k]),
            .o_valid(w_dv[k+1]),
            .i_ready(w_dr[k+1]),
            .o_div  (w_div[k+1])
        );
    end

    t_div        w_last;
    logic        w_go;
    logic        r_ov;
    logic [31:0] r_b0, r_b1, r_a1, r_a2;
    logic [1:0]  r_status;

    assign w_last     = w_div[QW];
    assign w_go       = !r_ov || i_out_ready;
    assign w_dr[QW]   = w_go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_go) begin
            r_ov <= w_dv[QW];
        end
        if (w_go && w_dv[QW]) begin
            r_status <= w_last.status;
            if (w_last.status == ST_QZERO) begin
                r_b0 <= '0;
                r_b1 <= '0;
                r_a1 <= '0;
                r_a2 <= '0;
            end else begin
                r_b0 <= sat_coef(w_last.nq_b0, 1'b0, 1'b0);
                r_b1 <= sat_coef(w_last.nq_b0, 1'b0, 1'b1);
                r_a1 <= sat_coef(w_last.nq_a1, w_last.neg_a1, 1'b0);
                r_a2 <= sat_coef(w_last.nq_a2, w_last.neg_a2, 1'b0);
            end
        end
    end

    assign o_out_valid = r_ov;
    assign o_coef_b0   = r_b0;
    assign o_coef_b1   = r_b1;
    assign o_coef_b2   = r_b0;
    assign o_coef_a1   = r_a1;
    assign o_coef_a2   = r_a2;
    assign o_status    = r_status;

endmodule
`default_nettype wire
